/* design/b2b_pkg.sv */
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared constants, types and a helper function for the BLAKE2b-512 hash block.
// ----------------------------------------------------------------------------
package b2b_pkg;

   localparam int ROUNDS_DEF = 12;
   localparam int WORD_W     = 64;
   localparam int CNT_W      = 4;
   localparam int BLK_WORDS  = 16;

   localparam logic [63:0] IV [8] = '{
      64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
      64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
      64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
      64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

   localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0040;

   // message schedule, one row per round modulo ten
   localparam logic [3:0] SIGMA [10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}};

   // controller to datapath commands
   typedef struct packed {
      logic       store;      // write the accepted word into the block
      logic       hold;       // capture the word that waits for a compression
      logic       store_held; // write the captured word instead of the input
      logic       init_work;  // load working vector for a compression
      logic       final_blk;  // compression is the final one
      logic       add_full;   // add 128 to the byte counter
      logic       add_tail;   // add the tail byte count
      logic       g_step;     // run one half-G step
      logic [3:0] round;      // current round modulo ten
      logic [2:0] g_idx;      // which of eight G in the round
      logic       g_half;     // first or second half of G
      logic       fold;       // fold working vector into chain value
      logic       restart;    // reload IV and clear counters
      logic [2:0] out_idx;    // digest word being presented
   } b2b_cmd_type;

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

endpackage

/* design/b2b_req_if.sv */
// ----------------------------------------------------------------------------
// b2b_req_if
// Message word channel: valid/ready handshake with word, count and last flag.
// ----------------------------------------------------------------------------
interface b2b_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  byte_count;
   logic        last_word;
   modport source (output valid, message_word, byte_count, last_word, input ready);
   modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

/* design/b2b_rsp_if.sv */
// ----------------------------------------------------------------------------
// b2b_rsp_if
// Digest word channel: valid/ready handshake with word and last flag.
// ----------------------------------------------------------------------------
interface b2b_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic        digest_last;
   modport source (output valid, digest_word, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

/* design/b2b_datapath.sv */
// ----------------------------------------------------------------------------
// b2b_datapath
// Block buffer, chain value, byte counter and one shared half-G mixing unit.
// ----------------------------------------------------------------------------
module b2b_datapath (
   input  logic                clock,
   input  logic                reset,
   input  b2b_pkg::b2b_cmd_type cmd,
   input  logic [63:0]         in_word,
   input  logic [3:0]          in_cnt,
   input  logic [4:0]          wr_idx,
   input  logic [4:0]          used_words,
   input  logic [7:0]          tail_bytes,
   output logic [63:0]         digest_word
);
   import b2b_pkg::*;

   logic [63:0] msg_ff [16];
   logic [63:0] held_ff;
   logic [63:0] h_ff [8];
   logic [63:0] h_in [8];
   logic [63:0] v_ff [16];
   logic [63:0] v_in [16];
   logic [63:0] cnt_lo_ff, cnt_lo_in, cnt_hi_ff, cnt_hi_in;
   logic [63:0] wdata;
   logic [63:0] masked;
   logic [3:0]  ia, ib, ic, id, sel;
   logic [63:0] a, b, c, d, m, a1, d1, c1, b1;
   logic [63:0] add_val;

   // byte mask for a short last word
   always_comb begin
      wdata = cmd.store_held ? held_ff : in_word;
      masked = wdata;
      for (int k = 0; k < 8; k++) begin
         if (in_cnt < 4'(k + 1)) masked[k*8 +: 8] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold) held_ff <= in_word;
      if (cmd.store) msg_ff[wr_idx[3:0]] <= masked;
   end

   // quarter-round indexes
   always_comb begin
      unique case (cmd.g_idx)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
      sel = SIGMA[cmd.round][{cmd.g_idx, cmd.g_half}];
      // words past the fill level read as zero padding
      m = ({1'b0, sel} < used_words) ? msg_ff[sel] : 64'd0;
      a = v_ff[ia]; b = v_ff[ib]; c = v_ff[ic]; d = v_ff[id];
      a1 = a + b + m;
      if (!cmd.g_half) begin
         d1 = ror64(d ^ a1, 32);
         c1 = c + d1;
         b1 = ror64(b ^ c1, 24);
      end else begin
         d1 = ror64(d ^ a1, 16);
         c1 = c + d1;
         b1 = ror64(b ^ c1, 63);
      end
   end

   always_comb begin
      add_val = cmd.add_full ? 64'd128 : {56'd0, tail_bytes};
      cnt_lo_in = cnt_lo_ff;
      cnt_hi_in = cnt_hi_ff;
      if (cmd.add_full || cmd.add_tail) begin
         cnt_lo_in = cnt_lo_ff + add_val;
         if (cnt_lo_in < add_val) cnt_hi_in = cnt_hi_ff + 64'd1;
      end
      if (cmd.restart) begin
         cnt_lo_in = '0;
         cnt_hi_in = '0;
      end
      v_in = v_ff;
      if (cmd.init_work) begin
         for (int k = 0; k < 8; k++) begin
            v_in[k] = h_ff[k];
            v_in[k+8] = IV[k];
         end
         v_in[12] = IV[4] ^ cnt_lo_ff;
         v_in[13] = IV[5] ^ cnt_hi_ff;
         if (cmd.final_blk) v_in[14] = ~IV[6];
      end else if (cmd.g_step) begin
         v_in[ia] = a1; v_in[ib] = b1; v_in[ic] = c1; v_in[id] = d1;
      end
      h_in = h_ff;
      if (cmd.fold) begin
         for (int k = 0; k < 8; k++) h_in[k] = h_ff[k] ^ v_ff[k] ^ v_ff[k+8];
      end
      if (cmd.restart) begin
         for (int k = 0; k < 8; k++) h_in[k] = IV[k];
         h_in[0] = IV[0] ^ PARAM_WORD;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (reset) begin
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         for (int k = 0; k < 8; k++) h_ff[k] <= IV[k];
         h_ff[0] <= IV[0] ^ PARAM_WORD;
      end else begin
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         h_ff <= h_in;
      end
   end

   assign digest_word = h_ff[cmd.out_idx];
endmodule

/* design/b2b_ctrl.sv */
// ----------------------------------------------------------------------------
// b2b_ctrl
// Sequencer: buffer fill, compression step count and digest output.
// ----------------------------------------------------------------------------
module b2b_ctrl #(
   parameter int ROUNDS = b2b_pkg::ROUNDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [3:0]           in_cnt_raw,
   input  logic                 in_last,
   output logic [3:0]           in_cnt,
   output logic [4:0]           wr_idx,
   output logic [4:0]           used_words,
   output logic [7:0]           tail_bytes,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_last,
   output b2b_pkg::b2b_cmd_type cmd
);
   import b2b_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INIT = 5'b00010,
      ST_MIX  = 5'b00100,
      ST_FOLD = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   localparam int RW = $clog2(ROUNDS + 1);

   state_type   state_ff, state_in;
   logic [4:0]  fill_ff, fill_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic [3:0]  rmod_ff, rmod_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  out_ff, out_in;
   logic        fin_ff, fin_in;       // compression in flight is final
   logic        pend_ff, pend_in;     // word waits for a full-block compression
   logic        plast_ff, plast_in;
   logic [3:0]  pcnt_ff, pcnt_in;
   logic        accept, empty_tail, cnt_eff_ok;
   logic [3:0]  cnt_eff;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign cnt_eff  = (!in_last || in_cnt_raw > 4'd8) ? 4'd8 : in_cnt_raw;
   assign empty_tail = in_last && cnt_eff == 4'd0 && fill_ff != 5'd0;
   assign cnt_eff_ok = 1'b1;
   assign out_valid = (state_ff == ST_OUT);
   assign out_last  = (out_ff == 3'd7);
   assign used_words = fill_ff;

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; rnd_in = rnd_ff; rmod_in = rmod_ff;
      step_in = step_ff; out_in = out_ff; fin_in = fin_ff;
      pend_in = pend_ff; plast_in = plast_ff; pcnt_in = pcnt_ff;
      cmd = '0;
      cmd.round = rmod_ff;
      cmd.g_idx = step_ff[3:1];
      cmd.g_half = step_ff[0];
      cmd.out_idx = out_ff;
      cmd.final_blk = fin_ff;
      in_cnt = pend_ff ? pcnt_ff : cnt_eff;
      wr_idx = fill_ff;
      tail_bytes = {fill_ff, 3'd0} - 8'd8 + {4'd0, in_cnt};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cnt_eff_ok) begin
               if (empty_tail) begin
                  tail_bytes = {fill_ff, 3'd0};
                  cmd.add_tail = 1'b1;
                  fin_in = 1'b1;
                  state_in = ST_INIT;
               end else if (fill_ff == 5'd16) begin
                  cmd.add_full = 1'b1;
                  cmd.hold = 1'b1;
                  fin_in = 1'b0;
                  pend_in = 1'b1; plast_in = in_last; pcnt_in = cnt_eff;
                  state_in = ST_INIT;
               end else begin
                  cmd.store = 1'b1;
                  fill_in = fill_ff + 5'd1;
                  if (in_last) begin
                     tail_bytes = {fill_ff, 3'd0} + {4'd0, cnt_eff};
                     cmd.add_tail = 1'b1;
                     fin_in = 1'b1;
                     state_in = ST_INIT;
                  end
               end
            end
         end
         ST_INIT: begin
            cmd.init_work = 1'b1;
            rnd_in = '0; rmod_in = '0; step_in = '0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.g_step = 1'b1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               rnd_in = rnd_ff + 1'b1;
               rmod_in = (rmod_ff == 4'd9) ? 4'd0 : rmod_ff + 4'd1;
               if (rnd_ff == RW'(ROUNDS - 1)) state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (fin_ff) begin
               out_in = '0;
               state_in = ST_OUT;
            end else begin
               // store the word that was waiting, as the first of a new block
               pend_in = 1'b0;
               cmd.store = 1'b1;
               cmd.store_held = 1'b1;
               wr_idx = 5'd0;
               fill_in = 5'd1;
               if (plast_ff) begin
                  tail_bytes = {4'd0, pcnt_ff};
                  cmd.add_tail = 1'b1;
                  fin_in = 1'b1;
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  fill_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         pend_ff <= 1'b0;
         out_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         out_ff <= out_in;
      end
      rnd_ff <= rnd_in; rmod_ff <= rmod_in; step_ff <= step_in;
      fin_ff <= fin_in; plast_ff <= plast_in; pcnt_ff <= pcnt_in;
   end
endmodule

/* design/blake2b_512_hash_top.sv */
// ----------------------------------------------------------------------------
// blake2b_512_hash_top
// Unkeyed BLAKE2b-512 over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Operation: a non-last word is stored into the block buffer when taken; a word that arrives on
//   a full block starts one compression and holds the input through INIT, MIX and FOLD.
// No new word is taken while a compression runs; each compression goes through the single
//   shared half-G unit (16 steps per round). Last word: the final compression runs (after the
//   full-block one, if a full block is pending), then the block offers eight digest items,
//   one per cycle while rsp.ready is high.
// Reset: synchronous; chain value loads the parameter-xored IV, counter clears.
module blake2b_512_hash_top #(
   parameter int ROUNDS = b2b_pkg::ROUNDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   b2b_req_if.sink   req,
   b2b_rsp_if.source rsp
);
   import b2b_pkg::*;

   b2b_cmd_type cmd;
   logic [3:0]  in_cnt;
   logic [4:0]  wr_idx;
   logic [4:0]  used_words;
   logic [7:0]  tail_bytes;

   // sequencer: decides when to store, compress and emit
   b2b_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_cnt_raw(req.byte_count), .in_last(req.last_word),
      .in_cnt, .wr_idx, .used_words, .tail_bytes,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_last(rsp.digest_last),
      .cmd
   );

   // storage and the shared mixing unit
   b2b_datapath u_dp (
      .clock, .reset, .cmd,
      .in_word(req.message_word), .in_cnt, .wr_idx, .used_words, .tail_bytes,
      .digest_word(rsp.digest_word)
   );

   // no new item is taken while digest items are on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input ready during output");

   // a taken last digest item leaves the output idle
   a_end_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.digest_last) |=> !rsp.valid)
      else $error("output continued after last digest item");
endmodule

/* dv/tb_blake2b_512_hash_top.sv */
// ----------------------------------------------------------------------------
// tb_blake2b_512_hash_top
// Self-checking bench for the BLAKE2b-512 hash block. A behavioral digest
// model predicts eight digest words per message. Directed messages cover the
// empty message, short tails, block boundaries and odd byte counts. Random
// messages follow a long receiver hold-off; sender bursts and receiver stalls run throughout.
// ----------------------------------------------------------------------------
module tb_blake2b_512_hash_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b2b_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } digest_item_type;

   logic clock;
   logic reset;

   b2b_req_if req ();
   b2b_rsp_if rsp ();

   blake2b_512_hash_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // model state: chain value, pending block and 128-bit byte counter
   logic [63:0]  mdl_chain [8];
   logic [63:0]  mdl_block [16];
   int unsigned  mdl_filled;
   logic [127:0] mdl_bytes;

   digest_item_type digest_q [$];
   int unsigned  mismatch_count;
   int unsigned  digest_count;
   int unsigned  message_count;
   int unsigned  words_sent;
   int unsigned  idle_cycles;
   bit           long_hold;
   bit           rsp_stall_on;

   // ------------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Count cycles with no handshake on either channel; a stuck block ends it.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_blake2b_512_hash_top: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Digest model
   // ------------------------------------------------------------------------
   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   task automatic mdl_restart();
      for (int i = 0; i < 8; i++) mdl_chain[i] = IV[i];
      mdl_chain[0] ^= PARAM_WORD;
      mdl_filled = 0;
      mdl_bytes  = '0;
   endtask

   // Run one compression over the first 'used' block words, rest as zero.
   task automatic mdl_compress(input int unsigned used, input bit is_final);
      logic [63:0] m [16];
      logic [63:0] v [16];
      int          a, b, c, d;
      int          ga [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
      int          gb [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
      int          gc [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
      int          gd [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
      for (int i = 0; i < 16; i++) m[i] = (i < used) ? mdl_block[i] : 64'd0;
      for (int i = 0; i < 8; i++) begin
         v[i]     = mdl_chain[i];
         v[i + 8] = IV[i];
      end
      v[12] ^= mdl_bytes[63:0];
      v[13] ^= mdl_bytes[127:64];
      if (is_final) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         for (int g = 0; g < 8; g++) begin
            a = ga[g]; b = gb[g]; c = gc[g]; d = gd[g];
            v[a] = v[a] + v[b] + m[SIGMA[r % 10][2 * g]];
            v[d] = rotr(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + m[SIGMA[r % 10][2 * g + 1]];
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 63);
         end
      end
      for (int i = 0; i < 8; i++) mdl_chain[i] ^= v[i] ^ v[i + 8];
   endtask

   // Advance the model by one accepted word; queue the digest on a last word.
   task automatic mdl_take_word(input logic [63:0] word, input logic [3:0] cnt,
                                input logic last);
      int unsigned  nbytes;
      int unsigned  tail;
      digest_item_type item;
      nbytes = (!last || cnt > 8) ? 8 : cnt;
      if (last && nbytes == 0 && mdl_filled > 0) begin
         tail = mdl_filled * 8;
      end else begin
         if (mdl_filled == 16) begin
            mdl_bytes += 128;
            mdl_compress(16, 1'b0);
            mdl_filled = 0;
         end
         if (nbytes < 8) word &= (64'd1 << (nbytes * 8)) - 64'd1;
         mdl_block[mdl_filled] = word;
         mdl_filled++;
         tail = (mdl_filled - 1) * 8 + nbytes;
      end
      if (last) begin
         mdl_bytes += tail;
         mdl_compress(mdl_filled, 1'b1);
         for (int i = 0; i < 8; i++) begin
            item.word = mdl_chain[i];
            item.last = (i == 7);
            digest_q.push_back(item);
         end
         mdl_restart();
         message_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   int unsigned burst_left;

   // Offer one item; insert a random gap between bursts, hold until accepted.
   task automatic send_word(input logic [63:0] word, input logic [3:0] cnt,
                            input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      burst_left--;
      req.valid        = 1'b1;
      req.message_word = word;
      req.byte_count   = cnt;
      req.last_word    = last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      mdl_take_word(word, cnt, last);
      words_sent++;
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Send a message of n bytes, closed by a last word; junk above the tail.
   task automatic send_message(input int unsigned nbytes, input bit empty_close,
                               input bit wild_counts);
      int unsigned full_words;
      int unsigned rest;
      logic [3:0]  cnt;
      full_words = nbytes / 8;
      rest       = nbytes % 8;
      for (int i = 0; i < full_words; i++) begin
         // when the tail is a full word, make that word the last one
         if (!empty_close && rest == 0 && i == full_words - 1) begin
            cnt = wild_counts ? 4'($urandom_range(8, 15)) : 4'd8;
            send_word(rand_word(), cnt, 1'b1);
            return;
         end
         cnt = wild_counts ? 4'($urandom_range(0, 15)) : 4'd8;
         send_word(rand_word(), cnt, 1'b0);
      end
      if (rest != 0) send_word(rand_word(), 4'(rest), 1'b1);
      else send_word(rand_word(), 4'd0, 1'b1);
   endtask

   task automatic wait_drained();
      while (digest_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver and checker
   // ------------------------------------------------------------------------
   initial begin
      rsp_stall_on = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp.ready <= 1'b0;
         end else if ($urandom_range(0, 31) == 0) begin
            rsp_stall_on = ~rsp_stall_on;
         end else begin
            // stall pattern: short stalls when on, free run when off
            rsp.ready <= rsp_stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      digest_item_type exp_item;
      if (!reset && rsp.valid && rsp.ready) begin
         digest_count++;
         if (digest_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest item %h last %b", rsp.digest_word,
                        rsp.digest_last);
         end else begin
            exp_item = digest_q.pop_front();
            if (rsp.digest_word !== exp_item.word || rsp.digest_last !== exp_item.last)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: exp %h/%b got %h/%b", exp_item.word,
                           exp_item.last, rsp.digest_word, rsp.digest_last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Empty message, tiny tails, block edges, extreme word values and counts.
   task automatic test_directed();
      send_word(64'd0, 4'd0, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
      send_word(64'd0, 4'd8, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
      send_word(64'hA5A5_5A5A_FFFF_0000, 4'd7, 1'b1);
      send_message(128, 1'b0, 1'b0);
      send_message(128, 1'b1, 1'b0);
      wait_drained();
   endtask

   // Messages that span multiple blocks, including an exact two-block message.
   task automatic test_block_edges();
      send_message(129, 1'b0, 1'b0);
      send_message(256, 1'b0, 1'b1);
      send_message(136, 1'b1, 1'b0);
      wait_drained();
   endtask

   // Hold the receiver for a long stretch while words keep coming.
   task automatic test_backpressure();
      long_hold = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end
         begin
            send_message(17, 1'b0, 1'b0);
            send_message(5, 1'b0, 1'b0);
            send_message(40, 1'b0, 1'b0);
         end
      join
      wait_drained();
   endtask

   // Random messages: mostly short, some multi-block, odd counts and closes.
   task automatic test_random();
      int unsigned nbytes;
      while (words_sent < 200) begin
         case ($urandom_range(0, 9))
            0:       nbytes = 0;
            1, 2:    nbytes = $urandom_range(100, 300);
            default: nbytes = $urandom_range(1, 64);
         endcase
         send_message(nbytes, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.message_word = '0;
      req.byte_count   = '0;
      req.last_word    = 1'b0;
      rsp.ready        = 1'b0;
      long_hold        = 1'b0;
      mismatch_count   = 0;
      digest_count     = 0;
      message_count    = 0;
      words_sent       = 0;
      idle_cycles      = 0;
      burst_left       = 0;
      mdl_restart();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_block_edges();
      test_backpressure();
      test_random();

      $display("covered %0d words in %0d messages, %0d digest items checked",
               words_sent, message_count, digest_count);
      if (mismatch_count == 0 && digest_q.size() == 0) begin
         $display("tb_blake2b_512_hash_top: clean");
      end else begin
         $display("%0d mismatches, %0d digest items missing", mismatch_count,
                  digest_q.size());
         $display("tb_blake2b_512_hash_top: errors");
      end
      $finish;
   end

endmodule
